// ===== design/csfu_pkg.sv =====
`default_nettype none
package csfu_pkg;
  localparam int MaxXDef  = 128;
  localparam int MaxYDef  = 128;
  localparam int MaxZDef  = 128;
  localparam int GuardDef = 1;
  localparam int DW       = 32;
  // floored product term and sum widths
  localparam int QW       = 2*DW - 14;
  localparam int RW       = QW + 2;

  typedef enum logic [2:0] {
    RegMode  = 3'd0,
    RegCoefX = 3'd1,
    RegCoefY = 3'd2,
    RegCoefZ = 3'd3,
    RegCoefT = 3'd4,
    RegDimX  = 3'd5,
    RegDimY  = 3'd6,
    RegDimZ  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } vec_t;

  // classified cell handed from front to back
  typedef struct packed {
    vec_t src;
    vec_t xm;
    vec_t ym;
    vec_t zm;
    vec_t old;
    vec_t cur;
    logic inner;
    logic last;
  } cell_t;

  // floor(p / 2^16) of a product
  function automatic logic signed [QW-1:0] shq(input logic signed [2*DW+1:0] p);
    shq = p[2*DW+1:16];
  endfunction

  function automatic logic signed [DW-1:0] sat(input logic signed [RW-1:0] v);
    if (v > $signed({{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}})) begin
      sat = {1'b0, {(DW-1){1'b1}}};
    end else if (v < $signed({{(RW-DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
      sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat = v[DW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== design/csfu_front.sv =====
`default_nettype none
module csfu_front #(
  parameter int MAX_X = csfu_pkg::MaxXDef,
  parameter int MAX_Y = csfu_pkg::MaxYDef,
  parameter int MAX_Z = csfu_pkg::MaxZDef,
  parameter int GUARD = csfu_pkg::GuardDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire csfu_pkg::vec_t src_i,
  input  wire csfu_pkg::vec_t old_i,
  input  wire csfu_pkg::vec_t cur_i,
  input  wire logic [7:0]     dim_x_i,
  input  wire logic [7:0]     dim_y_i,
  input  wire logic [7:0]     dim_z_i,
  output logic                cell_valid_o,
  input  wire logic           cell_ready_i,
  output csfu_pkg::cell_t     cell_o
);
  import csfu_pkg::*;
  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int PW = $clog2(MAX_Z + 1);
  localparam int CW = 11;

  logic [XW-1:0] px_q;
  logic [YW-1:0] py_q;
  logic [PW-1:0] pz_q;
  logic [CW-1:0] dx, dy, dz;
  logic wx, wy, wz, inner, fire;

  vec_t row_mem [MAX_X];
  vec_t plane_mem [2**(XW+YW)];
  vec_t prev_q;

  // stage 1 holds the item while store reads complete
  logic s1_v_q;
  vec_t s1_src_q, s1_old_q, s1_cur_q, s1_xm_q, s1_ym_q, s1_zm_q;
  logic s1_in_q, s1_last_q;

  function automatic logic [CW-1:0] effd(input logic [7:0] d, input int mx);
    logic [CW-1:0] e;
    e = {{(CW-8){1'b0}}, d};
    if (d == 8'd0) e = CW'(1);
    else if (e > CW'(mx)) e = CW'(mx);
    return e;
  endfunction

  assign dx = effd(dim_x_i, MAX_X);
  assign dy = effd(dim_y_i, MAX_Y);
  assign dz = effd(dim_z_i, MAX_Z);
  assign wx = CW'(px_q) + CW'(1) >= dx;
  assign wy = CW'(py_q) + CW'(1) >= dy;
  assign wz = CW'(pz_q) + CW'(1) >= dz;
  assign inner = CW'(px_q) >= CW'(GUARD) && CW'(px_q) + CW'(GUARD) < dx &&
                 CW'(py_q) >= CW'(GUARD) && CW'(py_q) + CW'(GUARD) < dy &&
                 CW'(pz_q) >= CW'(GUARD) && CW'(pz_q) + CW'(GUARD) < dz;

  assign in_ready_o   = !s1_v_q || cell_ready_i;
  assign fire         = in_valid_i && in_ready_o;
  assign cell_valid_o = s1_v_q;

  // stores: registered reads, write of the same cell after read
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_ym_q <= row_mem[px_q];
      s1_zm_q <= plane_mem[{py_q, px_q}];
      row_mem[px_q] <= src_i;
      plane_mem[{py_q, px_q}] <= src_i;
      s1_src_q  <= src_i;
      s1_old_q  <= old_i;
      s1_cur_q  <= cur_i;
      s1_xm_q   <= prev_q;
      s1_in_q   <= inner;
      s1_last_q <= wx && wy && wz;
    end
  end

  // position counters, previous cell and stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; pz_q <= '0; prev_q <= '0; s1_v_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_v_q <= in_valid_i;
      if (fire) begin
        prev_q <= src_i;
        if (wx) begin
          px_q <= '0;
          if (wy) begin
            py_q <= '0;
            pz_q <= wz ? '0 : pz_q + PW'(1);
          end else begin
            py_q <= py_q + YW'(1);
          end
        end else begin
          px_q <= px_q + XW'(1);
        end
      end
    end
  end

  assign cell_o = '{src: s1_src_q, xm: s1_xm_q, ym: s1_ym_q, zm: s1_zm_q,
                    old: s1_old_q, cur: s1_cur_q, inner: s1_in_q, last: s1_last_q};
endmodule
`default_nettype wire

// ===== design/csfu_fifo.sv =====
`default_nettype none
module csfu_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire csfu_pkg::cell_t in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output csfu_pkg::cell_t      out_o
);
  import csfu_pkg::*;
  cell_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/csfu_back.sv =====
`default_nettype none
module csfu_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   mode_i,
  input  wire logic signed [31:0]     coef_x_i,
  input  wire logic signed [31:0]     coef_y_i,
  input  wire logic signed [31:0]     coef_z_i,
  input  wire logic signed [31:0]     coef_t_i,
  input  wire logic                   cell_valid_i,
  output logic                        cell_ready_o,
  input  wire csfu_pkg::cell_t        cell_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output csfu_pkg::vec_t              new_o,
  output logic                        inner_o,
  output logic                        last_o
);
  import csfu_pkg::*;
  // stage a: differences; b: products; c: sum and saturate
  logic a_v_q, b_v_q, c_v_q, adv;
  logic signed [32:0] d_q [6];
  vec_t a_old_q, a_cur_q, b_old_q;
  logic a_in_q, a_last_q, b_in_q, b_last_q, b_mode_q;
  logic signed [QW-1:0] p_q [9];
  vec_t c_new_q;
  logic c_in_q, c_last_q;
  logic signed [QW-1:0] pr [9];
  logic signed [RW-1:0] r [3];
  logic signed [32:0] od [3];

  assign adv = !c_v_q || out_ready_i;
  assign cell_ready_o = adv;

  always_comb begin
    pr[0] = shq(66'(coef_y_i * d_q[0]));
    pr[1] = shq(66'(coef_z_i * d_q[1]));
    pr[2] = shq(66'(coef_z_i * d_q[2]));
    pr[3] = shq(66'(coef_x_i * d_q[3]));
    pr[4] = shq(66'(coef_x_i * d_q[4]));
    pr[5] = shq(66'(coef_y_i * d_q[5]));
    pr[6] = shq(66'(coef_t_i * $signed({a_cur_q.x[31], a_cur_q.x})));
    pr[7] = shq(66'(coef_t_i * $signed({a_cur_q.y[31], a_cur_q.y})));
    pr[8] = shq(66'(coef_t_i * $signed({a_cur_q.z[31], a_cur_q.z})));
    od[0] = 33'(b_old_q.x); od[1] = 33'(b_old_q.y); od[2] = 33'(b_old_q.z);
    for (int i = 0; i < 3; i++) begin
      if (!b_in_q) r[i] = RW'(od[i]);
      else if (b_mode_q)
        r[i] = RW'(od[i]) + RW'(p_q[2*i]) - RW'(p_q[2*i+1]) - RW'(p_q[6+i]);
      else
        r[i] = RW'(od[i]) - RW'(p_q[2*i]) + RW'(p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q[0] <= 33'(cell_i.src.z) - 33'(cell_i.ym.z);
      d_q[1] <= 33'(cell_i.src.y) - 33'(cell_i.zm.y);
      d_q[2] <= 33'(cell_i.src.x) - 33'(cell_i.zm.x);
      d_q[3] <= 33'(cell_i.src.z) - 33'(cell_i.xm.z);
      d_q[4] <= 33'(cell_i.src.y) - 33'(cell_i.xm.y);
      d_q[5] <= 33'(cell_i.src.x) - 33'(cell_i.ym.x);
      a_old_q <= cell_i.old; a_cur_q <= cell_i.cur;
      a_in_q <= cell_i.inner; a_last_q <= cell_i.last;
      for (int i = 0; i < 9; i++) p_q[i] <= pr[i];
      b_old_q <= a_old_q; b_in_q <= a_in_q; b_last_q <= a_last_q; b_mode_q <= mode_i;
      c_new_q <= '{z: sat(r[2]), y: sat(r[1]), x: sat(r[0])};
      c_in_q <= b_in_q; c_last_q <= b_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0; b_v_q <= 1'b0; c_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= cell_valid_i; b_v_q <= a_v_q; c_v_q <= b_v_q;
    end
  end

  assign out_valid_o = c_v_q;
  assign new_o = c_new_q;
  assign inner_o = c_in_q;
  assign last_o = c_last_q;
endmodule
`default_nettype wire

// ===== design/curl_stencil_field_update.sv =====
// Path: store read (front stage 1), queue, then three math stages; result registered.
// Throughput: one cell per cycle while the output is not stalled, with one read
// and one write per store for each accepted cell.
// Reset: asynchronous active low; clears position, previous cell, pipeline valids and
// registers (dims 128); row and plane stores are not cleared and hold data once written.
`default_nettype none
module curl_stencil_field_update #(
  parameter int MAX_X = csfu_pkg::MaxXDef,
  parameter int MAX_Y = csfu_pkg::MaxYDef,
  parameter int MAX_Z = csfu_pkg::MaxZDef,
  parameter int GUARD = csfu_pkg::GuardDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // src_x, src_y, src_z, old_x, old_y, old_z, cur_x, cur_y, cur_z
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // new_x, new_y, new_z
  output logic [95:0]       m_axis_tdata,
  // interior
  output logic              m_axis_tuser,
  // last_cell
  output logic              m_axis_tlast
);
  import csfu_pkg::*;
  logic mode_q;
  logic signed [31:0] cx_q, cy_q, cz_q, ct_q;
  logic [7:0] dx_q, dy_q, dz_q;
  logic f_v, f_r, q_v, q_r;
  cell_t f_cell, q_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; cx_q <= '0; cy_q <= '0; cz_q <= '0; ct_q <= '0;
      dx_q <= 8'd128; dy_q <= 8'd128; dz_q <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegMode:  mode_q <= cfg_data_i[0];
        RegCoefX: cx_q <= cfg_data_i;
        RegCoefY: cy_q <= cfg_data_i;
        RegCoefZ: cz_q <= cfg_data_i;
        RegCoefT: ct_q <= cfg_data_i;
        RegDimX:  dx_q <= cfg_data_i[7:0];
        RegDimY:  dy_q <= cfg_data_i[7:0];
        RegDimZ:  dz_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  csfu_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .GUARD(GUARD)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .src_i(s_axis_tdata[95:0]), .old_i(s_axis_tdata[191:96]), .cur_i(s_axis_tdata[287:192]),
    .dim_x_i(dx_q), .dim_y_i(dy_q), .dim_z_i(dz_q),
    .cell_valid_o(f_v), .cell_ready_i(f_r), .cell_o(f_cell));

  csfu_fifo u_fifo (.clk_i, .rst_ni, .in_valid_i(f_v), .in_ready_o(f_r), .in_i(f_cell),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(q_cell));

  csfu_back u_back (.clk_i, .rst_ni, .mode_i(mode_q), .coef_x_i(cx_q), .coef_y_i(cy_q),
    .coef_z_i(cz_q), .coef_t_i(ct_q), .cell_valid_i(q_v), .cell_ready_o(q_r),
    .cell_i(q_cell), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .new_o(m_axis_tdata), .inner_o(m_axis_tuser), .last_o(m_axis_tlast));
endmodule
`default_nettype wire

// ===== design/csfu_checker.sv =====
`default_nettype none
module csfu_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [95:0]  m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_side_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("side bits changed under stall");
  a_last_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser) else $error("last cell interior");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("stall with empty output");
endmodule

bind curl_stencil_field_update csfu_checker u_chk (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import csfu_pkg::*;

  localparam int DimMax    = 128;
  localparam int HoldOff   = 300;
  localparam int IdleLimit = 4000;
  localparam int Drain     = 10;

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic               interior;
    logic               last;
  } cell_result_t;

  // Curl update predictor plus the queue of predicted cell results
  class curl_scoreboard;
    logic               mode;
    logic signed [31:0] kx, ky, kz, kt;
    int                 dx, dy, dz;
    int                 px, py, pz;
    vec_t               prev;
    vec_t               row_src[DimMax];
    vec_t               plane_src[DimMax*DimMax];
    cell_result_t       pending_q[$];
    int                 errors;

    function void clear();
      mode = 0; kx = 0; ky = 0; kz = 0; kt = 0;
      dx = DimMax; dy = DimMax; dz = DimMax;
      px = 0; py = 0; pz = 0;
      prev = '0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        RegMode:  mode = v[0];
        RegCoefX: kx = v;
        RegCoefY: ky = v;
        RegCoefZ: kz = v;
        RegCoefT: kt = v;
        RegDimX:  dx = (v[7:0] == 0) ? 1 : (v[7:0] > DimMax) ? DimMax : v[7:0];
        RegDimY:  dy = (v[7:0] == 0) ? 1 : (v[7:0] > DimMax) ? DimMax : v[7:0];
        RegDimZ:  dz = (v[7:0] == 0) ? 1 : (v[7:0] > DimMax) ? DimMax : v[7:0];
        default: ;
      endcase
    endfunction

    // floor(c * (a - b) / 2^16), exact
    function logic signed [49:0] scaled_diff(logic signed [31:0] c, logic signed [31:0] a,
                                             logic signed [31:0] b);
      logic signed [32:0] d;
      logic signed [65:0] p;
      d = {a[31], a} - {b[31], b};
      p = c * d;
      return p[65:16];
    endfunction

    function logic signed [31:0] clamp(logic signed [63:0] v);
      if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void note(logic [287:0] d);
      vec_t               s, old, cur, ym, zm;
      logic signed [63:0] cv[3];
      logic signed [63:0] acc[3];
      logic signed [31:0] ov[3];
      logic signed [31:0] cvv[3];
      cell_result_t       r;
      int                 pidx;
      bit                 wx, wy, wz, inner;
      s   = '{z: d[95:64],   y: d[63:32],   x: d[31:0]};
      old = '{z: d[191:160], y: d[159:128], x: d[127:96]};
      cur = '{z: d[287:256], y: d[255:224], x: d[223:192]};
      pidx = py * DimMax + px;
      ym = row_src[px];
      zm = plane_src[pidx];
      wx = px + 1 >= dx; wy = py + 1 >= dy; wz = pz + 1 >= dz;
      inner = px >= 1 && px + 1 < dx && py >= 1 && py + 1 < dy && pz >= 1 && pz + 1 < dz;
      ov[0] = old.x; ov[1] = old.y; ov[2] = old.z;
      cvv[0] = cur.x; cvv[1] = cur.y; cvv[2] = cur.z;
      if (inner) begin
        cv[0] = scaled_diff(ky, s.z, ym.z) - scaled_diff(kz, s.y, zm.y);
        cv[1] = scaled_diff(kz, s.x, zm.x) - scaled_diff(kx, s.z, prev.z);
        cv[2] = scaled_diff(kx, s.y, prev.y) - scaled_diff(ky, s.x, ym.x);
        for (int i = 0; i < 3; i++) begin
          if (mode) acc[i] = ov[i] + cv[i] - scaled_diff(kt, cvv[i], 32'sd0);
          else      acc[i] = ov[i] - cv[i];
        end
      end else begin
        for (int i = 0; i < 3; i++) acc[i] = ov[i];
      end
      r.nx = clamp(acc[0]); r.ny = clamp(acc[1]); r.nz = clamp(acc[2]);
      r.interior = inner;
      r.last = wx && wy && wz;
      pending_q.push_back(r);
      prev = s;
      row_src[px] = s;
      plane_src[pidx] = s;
      // raster advance, x fastest
      if (wx) begin
        px = 0;
        if (wy) begin
          py = 0;
          pz = wz ? 0 : pz + 1;
        end else begin
          py++;
        end
      end else begin
        px++;
      end
    endfunction

    function void check(logic [95:0] d, logic user, logic last);
      cell_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result transfer: %h int %b last %b", d, user, last);
        return;
      end
      e = pending_q.pop_front();
      if (d[31:0] !== e.nx || d[63:32] !== e.ny || d[95:64] !== e.nz ||
          user !== e.interior || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h %h %h int %b last %b, got %h %h %h int %b last %b",
                   e.nx, e.ny, e.nz, e.interior, e.last,
                   d[31:0], d[63:32], d[95:64], user, last);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  curl_scoreboard cells = new();
  int  stall_pct = 0;
  int  gap_max = 0;
  int  burst_left = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;

  curl_stencil_field_update uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HoldOff;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready = 0;
    end else begin
      m_axis_tready = $urandom_range(0, 99) >= stall_pct;
    end
  end

  // transfer monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) cells.note(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        cells.check(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    cells.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic setup_grid(logic mode, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] ct, int nx, int ny, int nz);
    write_reg(RegMode, {31'd0, mode});
    write_reg(RegCoefX, cx);
    write_reg(RegCoefY, cy);
    write_reg(RegCoefZ, cz);
    write_reg(RegCoefT, ct);
    write_reg(RegDimX, 32'(nx));
    write_reg(RegDimY, 32'(ny));
    write_reg(RegDimZ, 32'(nz));
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  // one cell transfer, with bursty gaps ahead of it
  task automatic send_cell(logic [287:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 0;
        repeat ($urandom_range(0, gap_max)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tdata = d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic finish_grid();
    @(negedge clk_i);
    s_axis_tvalid = 0;
    while (cells.pending_q.size() > 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic random_grid(int nx, int ny, int nz);
    logic [287:0] d;
    setup_grid(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(), rand_word(),
               nx, ny, nz);
    for (int i = 0; i < nx * ny * nz; i++) begin
      for (int f = 0; f < 9; f++) d[f*32 +: 32] = rand_word();
      send_cell(d);
    end
    finish_grid();
  endtask

  initial begin
    logic [287:0] d;
    cells.clear();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // smallest grid with an interior cell, electric mode, extreme coefficients and field values
    setup_grid(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 3, 3, 3);
    for (int i = 0; i < 27; i++) begin
      for (int f = 0; f < 9; f++)
        case ((i + f) % 4)
          0: d[f*32 +: 32] = 32'h7fff_ffff;
          1: d[f*32 +: 32] = 32'h8000_0000;
          2: d[f*32 +: 32] = 32'h0;
          default: d[f*32 +: 32] = 32'hffff_ffff;
        endcase
      send_cell(d);
    end
    finish_grid();

    // largest row under a long receiver hold-off, then taller and deeper grids
    stall_pct = 30; gap_max = 6;
    hold_req = 1;
    random_grid(128, 3, 3);
    stall_pct = 0; gap_max = 0;
    random_grid(3, 20, 3);
    stall_pct = 60; gap_max = 3;
    random_grid(3, 3, 10);

    // small random grids under varied flow control
    for (int g = 0; g < 8; g++) begin
      stall_pct = (g % 3 == 0) ? 0 : $urandom_range(10, 70);
      gap_max = (g % 3 == 0) ? 0 : $urandom_range(1, 8);
      random_grid($urandom_range(3, 5), $urandom_range(3, 5), $urandom_range(3, 5));
    end

    if (cells.errors == 0 && cells.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
